### hdl/tstg_pkg.sv
// ----------------------------------------------------------------------------
// Tone generator package
// Shared types, constants and codes for the timed square wave tone generator.
// ----------------------------------------------------------------------------
package tstg_pkg;

	localparam int unsigned PERIOD_LIMIT = 256;
	localparam int unsigned US_PER_S     = 1000000;
	localparam int unsigned US_PER_MS    = 1000;

	localparam int unsigned FREQ_W   = 16;
	localparam int unsigned LEN_W    = 16;
	localparam int unsigned TOG_W    = 26;
	localparam int unsigned DIVR_W   = 20;
	localparam int unsigned STEP_W   = 5;
	localparam int unsigned HALF_STEPS = 20;

	localparam logic REQ_START = 1'b0;
	localparam logic REQ_TICK  = 1'b1;

	localparam logic [1:0] SEL_DIV1  = 2'd0;
	localparam logic [1:0] SEL_DIV4  = 2'd1;
	localparam logic [1:0] SEL_DIV16 = 2'd2;

	typedef enum logic [1:0] {
		STAT_OK   = 2'd0,
		STAT_ZERO = 2'd1,
		STAT_LOW  = 2'd2,
		STAT_HIGH = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_DIV1,
		S_DIV2,
		S_FINISH
	} state_t;

	typedef struct packed {
		logic              req_type;
		logic [FREQ_W-1:0] tone_freq_hz;
		logic [LEN_W-1:0]  tone_length_ms;
	} req_t;

	typedef struct packed {
		logic       buzzer_level;
		logic       running;
		logic [1:0] status;
	} rsp_t;

	typedef struct packed {
		logic [1:0]       sel;
		logic [7:0]       match;
		logic [TOG_W-1:0] toggles;
	} tstg_load_t;

	typedef struct packed {
		logic pin;
		logic on;
	} tstg_pin_t;

endpackage

### hdl/tstg_div.sv
// ----------------------------------------------------------------------------
// Shared restoring divider
// Produces one quotient bit per cycle for a given number of steps. The
// dividend is aligned to the top of its register.
// ----------------------------------------------------------------------------
module tstg_div (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [tstg_pkg::TOG_W-1:0]        dividend,
	input  logic [tstg_pkg::DIVR_W-1:0]       divisor,
	input  logic [tstg_pkg::STEP_W-1:0]       steps,
	output logic                              done,
	output logic [tstg_pkg::TOG_W-1:0]        quotient
);

	logic [tstg_pkg::DIVR_W-1:0] rem_q;
	logic [tstg_pkg::TOG_W-1:0]  quo_q;
	logic [tstg_pkg::DIVR_W-1:0] dvs_q;
	logic [tstg_pkg::STEP_W-1:0] cnt_q;
	logic                        busy_q;
	logic                        done_q;
	logic [tstg_pkg::DIVR_W:0]   shifted;
	logic                        ge;
	logic [tstg_pkg::DIVR_W:0]   diff;

	always_comb begin
		shifted = {rem_q, quo_q[tstg_pkg::TOG_W-1]};
		ge      = shifted >= {1'b0, dvs_q};
		diff    = shifted - {1'b0, dvs_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= steps;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == tstg_pkg::STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[tstg_pkg::DIVR_W-1:0] : shifted[tstg_pkg::DIVR_W-1:0];
			quo_q <= {quo_q[tstg_pkg::TOG_W-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

### hdl/tstg_timer.sv
// ----------------------------------------------------------------------------
// Prescaled tone timer
// Counts ticks through the prescaler and the 8-bit timer and toggles the
// output on each period match while toggles remain.
// ----------------------------------------------------------------------------
module tstg_timer (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   tick,
	input  logic                   stop,
	input  logic                   load,
	input  tstg_pkg::tstg_load_t   load_data,
	output tstg_pkg::tstg_pin_t    nxt
);

	logic [1:0]                 sel_q, sel_d;
	logic [7:0]                 match_q, match_d;
	logic [7:0]                 timer_q, timer_d;
	logic [3:0]                 pre_q, pre_d;
	logic [tstg_pkg::TOG_W-1:0] tog_q, tog_d;
	logic                       on_q, on_d;
	logic                       pin_q, pin_d;
	logic [4:0]                 pre_inc;
	logic [4:0]                 scale;

	always_comb begin
		case (sel_q)
			tstg_pkg::SEL_DIV1: scale = 5'd1;
			tstg_pkg::SEL_DIV4: scale = 5'd4;
			default:            scale = 5'd16;
		endcase
		pre_inc = {1'b0, pre_q} + 5'd1;

		sel_d   = sel_q;
		match_d = match_q;
		timer_d = timer_q;
		pre_d   = pre_q;
		tog_d   = tog_q;
		on_d    = on_q;
		pin_d   = pin_q;

		if (stop) begin
			on_d  = 1'b0;
			pin_d = 1'b0;
		end else if (load) begin
			sel_d   = load_data.sel;
			match_d = load_data.match;
			timer_d = '0;
			pre_d   = '0;
			tog_d   = load_data.toggles;
			on_d    = 1'b1;
		end else if (tick && on_q) begin
			if (pre_inc < scale) begin
				pre_d = pre_inc[3:0];
			end else begin
				pre_d = '0;
				if (timer_q != match_q) begin
					timer_d = timer_q + 8'd1;
				end else begin
					timer_d = '0;
					if (tog_q != '0) begin
						pin_d = !pin_q;
						tog_d = tog_q - 1'b1;
					end else begin
						on_d  = 1'b0;
						pin_d = 1'b0;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sel_q   <= tstg_pkg::SEL_DIV1;
			match_q <= '0;
			timer_q <= '0;
			pre_q   <= '0;
			tog_q   <= '0;
			on_q    <= 1'b0;
			pin_q   <= 1'b0;
		end else begin
			sel_q   <= sel_d;
			match_q <= match_d;
			timer_q <= timer_d;
			pre_q   <= pre_d;
			tog_q   <= tog_d;
			on_q    <= on_d;
			pin_q   <= pin_d;
		end
	end

	assign nxt.pin = pin_d;
	assign nxt.on  = on_d;

endmodule

### hdl/timed_square_wave_tone_generator.sv
// ----------------------------------------------------------------------------
// Timed square wave tone generator
// A tick or a zero-frequency start gives its result in the cycle after it is
// accepted, so such items can follow back to back while the output is free.
// Any other start runs a restoring division (20 steps) in one shared divider
// and, if the half period fits a band, a second one (26 steps); the input is
// held off meanwhile. Timer load and result follow once the output is free.
// Asynchronous reset stops the timer and drives the output low.
// ----------------------------------------------------------------------------
module timed_square_wave_tone_generator #(
	parameter int unsigned PERIOD_LIMIT = tstg_pkg::PERIOD_LIMIT
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_ready,
	input  tstg_pkg::req_t  req,
	output logic            rsp_valid,
	input  logic            rsp_ready,
	output tstg_pkg::rsp_t  rsp
);

	localparam logic [tstg_pkg::DIVR_W-1:0] LIMIT = tstg_pkg::DIVR_W'(PERIOD_LIMIT);
	localparam int unsigned ALIGN = tstg_pkg::TOG_W - tstg_pkg::HALF_STEPS;

	tstg_pkg::state_t    state_q, state_d;
	tstg_pkg::status_t   stat_q, stat_d;
	tstg_pkg::tstg_load_t load_q, load_d;
	tstg_pkg::tstg_pin_t tmr_nxt;
	tstg_pkg::rsp_t      rsp_q;

	logic                          rsp_valid_q;
	logic                          load_pend_q, load_pend_d;
	logic [tstg_pkg::TOG_W-1:0]    prod_q;
	logic                          out_free;
	logic                          accept;
	logic                          out_wr;
	tstg_pkg::status_t             out_status;
	logic                          tmr_tick, tmr_stop, tmr_load;
	logic                          div_start;
	logic [tstg_pkg::TOG_W-1:0]    div_dividend;
	logic [tstg_pkg::DIVR_W-1:0]   div_divisor;
	logic [tstg_pkg::STEP_W-1:0]   div_steps;
	logic                          div_done;
	logic [tstg_pkg::TOG_W-1:0]    div_quo;
	logic [tstg_pkg::DIVR_W-1:0]   half, q4, q16;

	assign out_free  = !rsp_valid_q || rsp_ready;
	assign req_ready = (state_q == tstg_pkg::S_IDLE) && out_free;
	assign accept    = req_valid && req_ready;

	assign half = div_quo[tstg_pkg::DIVR_W-1:0];
	assign q4   = half >> 2;
	assign q16  = half >> 4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tstg_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		stat_d       = stat_q;
		load_d       = load_q;
		load_pend_d  = load_pend_q;
		out_wr       = 1'b0;
		out_status   = tstg_pkg::STAT_OK;
		tmr_tick     = 1'b0;
		tmr_stop     = 1'b0;
		tmr_load     = 1'b0;
		div_start    = 1'b0;
		div_dividend = tstg_pkg::TOG_W'(tstg_pkg::US_PER_S) << ALIGN;
		div_divisor  = {3'b0, req.tone_freq_hz, 1'b0};
		div_steps    = tstg_pkg::STEP_W'(tstg_pkg::HALF_STEPS);
		case (state_q)
			tstg_pkg::S_IDLE: begin
				if (accept) begin
					if (req.req_type == tstg_pkg::REQ_TICK) begin
						tmr_tick = 1'b1;
						out_wr   = 1'b1;
					end else if (req.tone_freq_hz == '0) begin
						out_wr     = 1'b1;
						out_status = tstg_pkg::STAT_ZERO;
					end else begin
						tmr_stop    = 1'b1;
						div_start   = 1'b1;
						load_pend_d = 1'b0;
						state_d     = tstg_pkg::S_DIV1;
					end
				end
			end
			tstg_pkg::S_DIV1: begin
				div_dividend = prod_q;
				div_divisor  = half;
				div_steps    = tstg_pkg::STEP_W'(tstg_pkg::TOG_W);
				if (div_done) begin
					state_d = tstg_pkg::S_FINISH;
					if (half == '0) begin
						stat_d = tstg_pkg::STAT_HIGH;
					end else if (half <= LIMIT) begin
						load_d.sel   = tstg_pkg::SEL_DIV1;
						load_d.match = 8'(half - 1'b1);
						div_start    = 1'b1;
						state_d      = tstg_pkg::S_DIV2;
					end else if (q4 <= LIMIT) begin
						load_d.sel   = tstg_pkg::SEL_DIV4;
						load_d.match = 8'(q4 - 1'b1);
						div_start    = 1'b1;
						state_d      = tstg_pkg::S_DIV2;
					end else if (q16 <= LIMIT) begin
						load_d.sel   = tstg_pkg::SEL_DIV16;
						load_d.match = 8'(q16 - 1'b1);
						div_start    = 1'b1;
						state_d      = tstg_pkg::S_DIV2;
					end else begin
						stat_d = tstg_pkg::STAT_LOW;
					end
				end
			end
			tstg_pkg::S_DIV2: begin
				if (div_done) begin
					load_d.toggles = div_quo;
					load_pend_d    = 1'b1;
					stat_d         = tstg_pkg::STAT_OK;
					state_d        = tstg_pkg::S_FINISH;
				end
			end
			tstg_pkg::S_FINISH: begin
				if (out_free) begin
					tmr_load    = load_pend_q;
					load_pend_d = 1'b0;
					out_wr      = 1'b1;
					out_status  = stat_q;
					state_d     = tstg_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = tstg_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
			load_pend_q <= 1'b0;
		end else begin
			load_pend_q <= load_pend_d;
			if (out_wr) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		stat_q <= stat_d;
		load_q <= load_d;
		if (accept) begin
			prod_q <= tstg_pkg::TOG_W'(req.tone_length_ms) *
				tstg_pkg::TOG_W'(tstg_pkg::US_PER_MS);
		end
		if (out_wr) begin
			rsp_q.buzzer_level <= tmr_nxt.pin;
			rsp_q.running      <= tmr_nxt.on;
			rsp_q.status       <= out_status;
		end
	end

	tstg_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.steps    (div_steps),
		.done     (div_done),
		.quotient (div_quo)
	);

	tstg_timer u_timer (
		.clk       (clk),
		.arst_n    (arst_n),
		.tick      (tmr_tick),
		.stop      (tmr_stop),
		.load      (tmr_load),
		.load_data (load_q),
		.nxt       (tmr_nxt)
	);

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

### dv/tstg_checker.sv
// ----------------------------------------------------------------------------
// Tone generator checker
// Watches both channels of the tone generator. Each accepted request item
// advances a cycle-free copy of the tone timer, which yields the response
// the block must return for it. Each accepted response item is compared
// field by field with the oldest awaited response.
// ----------------------------------------------------------------------------
module tstg_checker
	import tstg_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	input  logic        req_ready,
	input  req_t        req,
	input  logic        rsp_valid,
	input  logic        rsp_ready,
	input  rsp_t        rsp,
	output int unsigned pending,
	output int unsigned errors
);

	logic [TOG_W-1:0] tone_toggles;
	logic [7:0]       tone_match;
	logic [7:0]       tone_count;
	logic [1:0]       tone_sel;
	logic [4:0]       tone_presc;
	logic             tone_on;
	logic             tone_pin;

	rsp_t awaited_rsp[$];

	function automatic rsp_t advance_tone(req_t item);
		rsp_t            res;
		status_t         st;
		int unsigned     half;
		int unsigned     pr;
		int unsigned     step_div;
		longint unsigned budget;
		logic [1:0]      sel;
		logic            loaded;
		st = STAT_OK;
		pr = 0;
		sel = SEL_DIV1;
		if (item.req_type == REQ_START) begin
			if (item.tone_freq_hz == '0) begin
				st = STAT_ZERO;
			end else begin
				tone_on = 1'b0;
				tone_pin = 1'b0;
				half = (US_PER_S / item.tone_freq_hz) / 2;
				loaded = 1'b1;
				if (half == 0) begin
					st = STAT_HIGH;
					loaded = 1'b0;
				end else if (half <= PERIOD_LIMIT) begin
					sel = SEL_DIV1;
					pr = half - 1;
				end else if (half / 4 <= PERIOD_LIMIT) begin
					sel = SEL_DIV4;
					pr = half / 4 - 1;
				end else if (half / 16 <= PERIOD_LIMIT) begin
					sel = SEL_DIV16;
					pr = half / 16 - 1;
				end else begin
					st = STAT_LOW;
					loaded = 1'b0;
				end
				if (loaded) begin
					tone_sel = sel;
					tone_match = pr[7:0];
					tone_count = '0;
					tone_presc = '0;
					budget = (longint'(item.tone_length_ms) * US_PER_MS) / half;
					tone_toggles = budget[TOG_W-1:0];
					tone_on = 1'b1;
				end
			end
		end else if (tone_on) begin
			step_div = (tone_sel == SEL_DIV1) ? 1 : (tone_sel == SEL_DIV4) ? 4 : 16;
			tone_presc = tone_presc + 5'd1;
			if (tone_presc >= step_div) begin
				tone_presc = '0;
				if (tone_count != tone_match) begin
					tone_count = tone_count + 8'd1;
				end else begin
					tone_count = '0;
					if (tone_toggles != '0) begin
						tone_pin = ~tone_pin;
						tone_toggles = tone_toggles - 1'b1;
					end else begin
						tone_on = 1'b0;
						tone_pin = 1'b0;
					end
				end
			end
		end
		res.buzzer_level = tone_pin;
		res.running = tone_on;
		res.status = st;
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		rsp_t exp_rsp;
		if (!arst_n) begin
			tone_toggles = '0;
			tone_match = '0;
			tone_count = '0;
			tone_sel = SEL_DIV1;
			tone_presc = '0;
			tone_on = 1'b0;
			tone_pin = 1'b0;
			awaited_rsp.delete();
			pending = 0;
			errors = 0;
		end else begin
			// A response can never stem from a request taken at the same edge.
			if (rsp_valid && rsp_ready) begin
				if (awaited_rsp.size() == 0) begin
					$error("response item arrived with none awaited");
					errors++;
				end else begin
					exp_rsp = awaited_rsp.pop_front();
					if (rsp.buzzer_level !== exp_rsp.buzzer_level) begin
						$error("buzzer_level: expected %0d, actual %0d",
							exp_rsp.buzzer_level, rsp.buzzer_level);
						errors++;
					end
					if (rsp.running !== exp_rsp.running) begin
						$error("running: expected %0d, actual %0d",
							exp_rsp.running, rsp.running);
						errors++;
					end
					if (rsp.status !== exp_rsp.status) begin
						$error("status: expected %0d, actual %0d",
							exp_rsp.status, rsp.status);
						errors++;
					end
				end
			end
			if (req_valid && req_ready) begin
				awaited_rsp.push_back(advance_tone(req));
			end
			pending = awaited_rsp.size();
		end
	end

endmodule

### dv/testbench.sv
// ----------------------------------------------------------------------------
// Tone generator testbench
// Drives start and tick items into the timed square wave tone generator:
// a short directed run over the frequency bands and boundaries, then random
// tone sequences with bursty idling on both channels, a long response stall
// and a full drain, and finally a short tone with no idling that runs to its end.
// ----------------------------------------------------------------------------
module testbench;
	import tstg_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam int unsigned HOLD_CYCLES = 300;
	localparam int unsigned RANDOM_ITEMS = 500;

	logic        clk;
	logic        arst_n;
	logic        req_valid;
	logic        req_ready;
	req_t        req;
	logic        rsp_valid;
	logic        rsp_ready;
	rsp_t        rsp;
	int unsigned pending;
	int unsigned errors;

	int unsigned cycles;
	int unsigned items_sent;
	bit          bursty;
	bit          quiet;
	bit          hold_rsp;

	timed_square_wave_tone_generator u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	tstg_checker u_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp),
		.pending   (pending),
		.errors    (errors)
	);

	initial begin
		clk = 1'b0;
	end

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("testbench: FAIL");
			$finish;
		end
	end

	function automatic req_t tone_start(int unsigned freq, int unsigned len);
		req_t item;
		item.req_type = REQ_START;
		item.tone_freq_hz = freq[FREQ_W-1:0];
		item.tone_length_ms = len[LEN_W-1:0];
		return item;
	endfunction

	function automatic req_t tone_tick();
		req_t item;
		item.req_type = REQ_TICK;
		item.tone_freq_hz = FREQ_W'($urandom);
		item.tone_length_ms = LEN_W'($urandom);
		return item;
	endfunction

	task automatic offer(input req_t item);
		if (bursty && !quiet && $urandom_range(0, 3) == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(negedge clk);
		end
		req <= item;
		req_valid <= 1'b1;
		do @(posedge clk); while (!req_ready);
		@(negedge clk);
		items_sent++;
	endtask

	task automatic run_ticks(input int unsigned count);
		repeat (count) offer(tone_tick());
	endtask

	// The response side: random stalls, one long hold on request, none when quiet.
	initial begin
		rsp_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_rsp) begin
				rsp_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_rsp = 1'b0;
				rsp_ready <= 1'b1;
			end else if (!quiet && $urandom_range(0, 7) == 0) begin
				rsp_ready <= 1'b0;
				repeat ($urandom_range(1, 12)) @(negedge clk);
				rsp_ready <= 1'b1;
			end else begin
				rsp_ready <= 1'b1;
			end
		end
	end

	initial begin
		req_t item;
		bit   held;
		bit   drained;
		cycles = 0;
		items_sent = 0;
		bursty = 1'b0;
		quiet = 1'b0;
		hold_rsp = 1'b0;
		held = 1'b0;
		drained = 1'b0;
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Band edges: too low below 122 Hz, the boundary between no prescaling and divide-by-4, top rate.
		offer(tone_tick());
		offer(tone_start(0, 65535));
		offer(tone_start(1, 100));
		offer(tone_start(121, 5));
		offer(tone_start(122, 0));
		offer(tone_start(1953, 1));
		offer(tone_start(1945, 2));
		offer(tone_start(65535, 0));
		run_ticks(8);
		offer(tone_start(65535, 65535));
		run_ticks(3);
		offer(tone_start(40000, 0));

		items_sent = 0;
		while (items_sent < RANDOM_ITEMS) begin
			bursty = ($urandom_range(0, 2) != 0);
			if (!held && items_sent >= 150) begin
				hold_rsp = 1'b1;
				held = 1'b1;
			end
			if (!drained && items_sent >= 320) begin
				req_valid <= 1'b0;
				wait (pending == 0);
				@(negedge clk);
				drained = 1'b1;
			end
			case ($urandom_range(0, 9))
				0: begin
					item.req_type = 1'($urandom_range(0, 1));
					item.tone_freq_hz = FREQ_W'($urandom);
					item.tone_length_ms = LEN_W'($urandom);
					offer(item);
				end
				1: begin
					offer(tone_start($urandom_range(0, 65535), $urandom_range(0, 65535)));
					run_ticks($urandom_range(1, 6));
					offer(tone_start($urandom_range(0, 65535), $urandom_range(0, 65535)));
				end
				2: begin
					offer(tone_start($urandom_range(122, 2000), $urandom_range(0, 65535)));
					run_ticks($urandom_range(10, 60));
				end
				default: begin
					offer(tone_start($urandom_range(20000, 65535), $urandom_range(0, 1)));
					run_ticks($urandom_range(5, 90));
				end
			endcase
		end

		// A tone with no toggles left stops at its first period match, eight ticks in.
		quiet = 1'b1;
		offer(tone_start(62500, 0));
		run_ticks(12);

		req_valid <= 1'b0;
		wait (pending == 0);
		repeat (100) @(negedge clk);
		if (errors == 0) begin
			$display("testbench: PASS");
		end else begin
			$display("testbench: FAIL");
		end
		$finish;
	end

endmodule
